@@ hw/rtl/bcc_pkg.sv @@
package bcc_pkg;

   localparam int CAPACITY      = 64;
   localparam int NUMBER_BITS   = 32;
   localparam int POSITION_BITS = 32;
   localparam int SLOT_BITS     = $clog2(CAPACITY);
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int KEY_BITS      = 2 + NUMBER_BITS;
   localparam int NU_BITS       = 1 + POSITION_BITS;
   localparam logic [6:0] CAPACITY_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  access_type;
      logic [31:0] access_number;
      logic        has_next_use;
      logic [31:0] next_use_position;
   } req_payload_type;

   typedef struct packed {
      logic        hit;
      logic [5:0]  slot;
      logic        evicted;
      logic [1:0]  evicted_type;
      logic [31:0] evicted_number;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SCAN,
      ST_WRITE,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request, clear the scan index
      logic step;       // advance the scan index by one slot
      logic lookup;     // this scan step compares keys
      logic victim;     // this scan step looks for the victim
      logic restart;    // reset the scan index to slot zero
      logic commit;     // update the slot tables
      logic show;       // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // the current scan index is the final slot
      logic found;      // lookup found the key
      logic must_evict; // the cache is full for this miss
      logic stop_early; // victim scan met a slot that is never used again
   } status_type;

endpackage

@@ hw/rtl/belady_container_cache_top.sv @@
// Optimal-replacement cache of container keys (type, number).
// Each request beat on req_ carries a key and the trace position of that key's
// next access; one response beat on rsp_ follows it, giving hit, the slot that
// holds the key, and the evicted key on a miss to a full cache.
// The csr_ port writes the capacity limit; write it only while the block is idle.
// The request is captured at acceptance, followed by a lookup scan of every
// slot (one slot per cycle through the key table), a decision state, on a
// full-cache miss a victim scan that stops early at a slot that is never used
// again, and an update state; then the response beat is offered. Once it has
// been taken, the block returns to idle before it accepts the next request.
// A single item is in flight at a time; req_stall is high from acceptance until
// the response beat has been taken.
// Reset empties the cache, forgets the previous key and sets capacity to 64.
// While rsp_stall is high during a response, the response beat holds steady and no request is taken.
module belady_container_cache_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bcc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bcc_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [6:0]               csr_data
);
   import bcc_pkg::*;

   // Commands and status are the only link between controller and datapath.
   cmd_type    cmd;
   status_type status;

   bcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bcc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/bcc_ctrl.sv @@
module bcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bcc_pkg::status_type status,
   output bcc_pkg::cmd_type    cmd
);
   import bcc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            cmd.step   = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.restart = 1'b1;
            if (!status.found && status.must_evict) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_SCAN: begin
            cmd.victim = 1'b1;
            cmd.step   = 1'b1;
            if (status.scan_last || status.stop_early) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            cmd.show   = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/bcc_datapath.sv @@
module bcc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [6:0]               csr_data,
   input  bcc_pkg::req_payload_type req_payload,
   input  bcc_pkg::cmd_type         cmd,
   output bcc_pkg::status_type      status,
   output bcc_pkg::rsp_payload_type rsp_payload
);
   import bcc_pkg::*;

   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [NU_BITS-1:0]  nu_mem  [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;

   logic [6:0]            capacity_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [KEY_BITS-1:0]   last_key_ff;
   logic                  last_valid_ff;

   logic [KEY_BITS-1:0]   key_ff;
   logic [NU_BITS-1:0]    nu_ff;
   logic                  refresh_ff;
   logic [SLOT_BITS-1:0]  idx_ff;
   logic                  found_ff;
   logic [SLOT_BITS-1:0]  hit_slot_ff;
   logic                  free_found_ff;
   logic [SLOT_BITS-1:0]  free_slot_ff;
   logic                  vic_found_ff;
   logic [SLOT_BITS-1:0]  vic_slot_ff;
   logic [POSITION_BITS-1:0] vic_pos_ff;
   logic                  evict_ff;
   rsp_payload_type       rsp_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [NU_BITS-1:0]    rd_nu_ff;

   logic [KEY_BITS-1:0]   in_key;
   logic [NU_BITS-1:0]    in_nu;
   logic                  rd_valid;
   logic [COUNT_BITS-1:0] eff_cap;
   logic [SLOT_BITS-1:0]  ins_slot;
   logic [SLOT_BITS-1:0]  idx_in;

   assign in_key = {req_payload.access_type, req_payload.access_number[NUMBER_BITS-1:0]};
   assign in_nu  = {req_payload.has_next_use,
                    req_payload.has_next_use ?
                    req_payload.next_use_position[POSITION_BITS-1:0] : POSITION_BITS'(0)};

   // The tables are read at the next scan index so that the registered read
   // data lines up with idx_ff.
   always_comb begin
      if (cmd.load || cmd.restart) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + SLOT_BITS'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   assign rd_valid = valid_ff[idx_ff];

   always_comb begin
      if (capacity_ff == 7'd0) begin
         eff_cap = COUNT_BITS'(1);
      end else if ({25'd0, capacity_ff} > CAPACITY) begin
         eff_cap = COUNT_BITS'(CAPACITY);
      end else begin
         eff_cap = COUNT_BITS'(capacity_ff);
      end
   end

   assign status.scan_last  = (idx_ff == SLOT_BITS'(CAPACITY - 1));
   assign status.found      = found_ff;
   assign status.must_evict = (count_ff >= eff_cap) && (count_ff != '0);
   assign status.stop_early = rd_valid && !rd_nu_ff[NU_BITS-1];

   assign ins_slot = found_ff ? hit_slot_ff : (evict_ff ? vic_slot_ff : free_slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         capacity_ff   <= CAPACITY_RESET;
         count_ff      <= '0;
         last_key_ff   <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            capacity_ff <= csr_data;
         end
         if (cmd.load) begin
            last_key_ff   <= in_key;
            last_valid_ff <= 1'b1;
         end
         if (cmd.commit && !found_ff) begin
            valid_ff[ins_slot] <= 1'b1;
            if (!evict_ff) begin
               count_ff <= count_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      rd_key_ff <= key_mem[idx_in];
      rd_nu_ff  <= nu_mem[idx_in];
      if (cmd.load) begin
         key_ff        <= in_key;
         nu_ff         <= in_nu;
         refresh_ff    <= !last_valid_ff || (last_key_ff != in_key);
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         evict_ff      <= 1'b0;
      end
      if (cmd.lookup) begin
         if (rd_valid && rd_key_ff == key_ff && !found_ff) begin
            found_ff    <= 1'b1;
            hit_slot_ff <= idx_ff;
         end
         if (!rd_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= idx_ff;
         end
      end
      if (cmd.restart) begin
         evict_ff <= !found_ff && status.must_evict;
      end
      if (cmd.victim && rd_valid) begin
         if (!rd_nu_ff[NU_BITS-1]) begin
            vic_slot_ff  <= idx_ff;
            vic_found_ff <= 1'b1;
         end else if (!vic_found_ff || rd_nu_ff[POSITION_BITS-1:0] > vic_pos_ff) begin
            vic_slot_ff  <= idx_ff;
            vic_pos_ff   <= rd_nu_ff[POSITION_BITS-1:0];
            vic_found_ff <= 1'b1;
         end
      end
      if (cmd.commit) begin
         if (!found_ff || refresh_ff) begin
            nu_mem[ins_slot] <= nu_ff;
         end
         if (!found_ff) begin
            key_mem[ins_slot] <= key_ff;
         end
      end
      if (cmd.show) begin
         rsp_ff.hit     <= found_ff;
         rsp_ff.slot    <= 6'(ins_slot);
         rsp_ff.evicted <= evict_ff;
         rsp_ff.evicted_type   <= evict_ff ? key_mem[ins_slot][KEY_BITS-1 -: 2] : 2'd0;
         rsp_ff.evicted_number <= evict_ff ? 32'(key_mem[ins_slot][NUMBER_BITS-1:0]) : 32'd0;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/bcc_checker.sv @@
module bcc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input bcc_pkg::rsp_payload_type rsp_payload
);
   import bcc_pkg::*;

   // A response beat is never offered while a request is being taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("request accepted while a response is pending");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> !rsp_payload.evicted)
      else $error("hit reported with eviction");

   // An accepted request is never answered in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too early");

   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind belady_container_cache_top bcc_checker u_bcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
